// ----- design/spiwf_pkg.sv -----
// Shared types, register numbers and the CRC-8 byte function of the SPI write framer.
package spiwf_pkg;

  // Target register numbers of the write frames
  localparam logic [7:0] REG_LOW       = 8'h3E;
  localparam logic [7:0] REG_HIGH      = 8'h3F;
  localparam logic [7:0] DATA_REG_BASE = 8'h40;
  localparam logic [7:0] REG_SUM       = 8'h60;
  localparam logic [7:0] REG_LEN       = 8'h61;
  localparam logic [7:0] WRITE_FLAG    = 8'h80;
  localparam logic [7:0] LEN_OFFSET    = 8'd4;
  localparam logic [7:0] CRC_POLY      = 8'h07;

  // Request codes
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_MEMORY  = 1'b1;

  // Request held while its frames go out
  typedef struct packed {
    logic        op;
    logic [15:0] address;
    logic [31:0] payload;
    logic [2:0]  count;    // already clamped to the data byte limit
    logic [7:0]  sum;      // inverted byte sum of address and data
  } item_t;

  // One frame and its end-of-run flag
  typedef struct packed {
    logic [7:0] register_num;
    logic [7:0] value;
    logic [7:0] crc;
    logic       last;
  } frame_t;

  // CRC-8 of one byte from a zero register; a running CRC c over byte b
  // equals crc8_byte(c ^ b)
  function automatic logic [7:0] crc8_byte(input logic [7:0] b);
    logic [7:0] crc;
    crc = b;
    for (int i = 0; i < 8; i++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ----- design/spiwf_frame_gen.sv -----
// Frame selection and CRC for one frame index of the held request.
module spiwf_frame_gen import spiwf_pkg::*; #(
  parameter int MAX_DATA_BYTES = 4,
  parameter int FRAME_W        = $clog2(MAX_DATA_BYTES + 4)
) (
  input  item_t              item,
  input  logic [FRAME_W-1:0] idx,
  output frame_t             frame
);

  localparam int DIDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  logic [FRAME_W-1:0] cnt;
  logic [FRAME_W-1:0] didx;
  logic [DIDX_W-1:0]  dsel;
  logic [7:0]         dbyte;
  logic [7:0]         reg_num;
  logic [7:0]         first;
  logic [7:0]         value;

  assign cnt  = FRAME_W'(item.count);
  assign didx = idx - FRAME_W'(2);
  assign dsel = didx[DIDX_W-1:0];
  assign dbyte = item.payload[8*dsel +: 8];

  // Pick target register and value by position in the run
  always_comb begin
    priority if (idx == FRAME_W'(0)) begin
      reg_num = REG_LOW;
      value   = item.address[7:0];
    end else if (idx == FRAME_W'(1) || item.op == OP_COMMAND) begin
      reg_num = REG_HIGH;
      value   = item.address[15:8];
    end else if (didx < cnt) begin
      reg_num = DATA_REG_BASE + 8'(didx);
      value   = dbyte;
    end else if (didx == cnt) begin
      reg_num = REG_SUM;
      value   = item.sum;
    end else begin
      reg_num = REG_LEN;
      value   = 8'(item.count) + LEN_OFFSET;
    end
  end

  assign first              = WRITE_FLAG | reg_num;
  assign frame.register_num = first;
  assign frame.value        = value;
  assign frame.crc          = crc8_byte(crc8_byte(first) ^ value);
  assign frame.last         = (item.op == OP_MEMORY) ? (idx == cnt + FRAME_W'(3))
                                                     : (idx == FRAME_W'(1));

endmodule

// ----- design/spi_register_write_framer_unit.sv -----
// Top level of the SPI register write framer: request register, frame counter, result register.
//
// Each accepted request becomes a run of 3-byte SPI write frames, one frame
// per result item with tlast on the final one: two frames (registers 0x3E and
// 0x3F) for a command-only subcommand, and byte_count + 4 frames for a memory
// write, with byte_count clamped to MAX_DATA_BYTES (0 gives four frames). The
// frame counter steps through the held request at one frame per cycle while the
// result side keeps taking items and holds while out_tready stays low. The next
// request is taken in the cycle in which the final frame of the current one
// enters the result register, so runs follow each other without a gap.
module spi_register_write_framer_unit import spiwf_pkg::*; #(
  parameter int MAX_DATA_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] address, [47:16] payload, [50:48] byte_count, [55:51] zero
  input  logic [55:0] in_tdata,
  // [0] op
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] frame_register, [15:8] frame_value, [23:16] frame_crc
  output logic [23:0] out_tdata,
  output logic        out_tlast
);

  localparam int FRAME_W = $clog2(MAX_DATA_BYTES + 4);

  item_t              item_r, item_nxt;
  logic               busy_r, busy_nxt;
  logic [FRAME_W-1:0] idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  frame_t             out_frame_r, out_frame_nxt;
  frame_t             frame;
  logic               load;
  logic               in_fire;
  logic [2:0]         cnt_in;
  logic [7:0]         sum_in;

  // Clamp the byte count and form the checksum of the incoming request
  always_comb begin
    cnt_in = (in_tdata[50:48] > 3'(MAX_DATA_BYTES)) ? 3'(MAX_DATA_BYTES)
                                                    : in_tdata[50:48];
    sum_in = in_tdata[7:0] + in_tdata[15:8];
    for (int i = 0; i < MAX_DATA_BYTES; i++) begin
      if (3'(i) < cnt_in) begin
        sum_in = sum_in + in_tdata[16 + 8*i +: 8];
      end
    end
  end

  spiwf_frame_gen #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .FRAME_W        (FRAME_W)
  ) u_frame_gen (
    .item  (item_r),
    .idx   (idx_r),
    .frame (frame)
  );

  // While a request is held, load a frame whenever the result register is free or being emptied
  assign load      = busy_r && (!out_valid_r || out_tready);
  assign in_tready = !busy_r || (load && frame.last);
  assign in_fire   = in_tvalid && in_tready;

  // Advance the frame counter, take the next request at the end of a run
  always_comb begin
    item_nxt      = item_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_frame_nxt = out_frame_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_frame_nxt = frame;
      idx_nxt       = idx_r + FRAME_W'(1);
      if (frame.last) begin
        busy_nxt = 1'b0;
      end
    end
    if (in_fire) begin
      item_nxt.op      = in_tuser;
      item_nxt.address = in_tdata[15:0];
      item_nxt.payload = in_tdata[47:16];
      item_nxt.count   = cnt_in;
      item_nxt.sum     = ~sum_in;
      busy_nxt         = 1'b1;
      idx_nxt          = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    out_frame_r <= out_frame_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_frame_r.crc, out_frame_r.value, out_frame_r.register_num};
  assign out_tlast  = out_frame_r.last;

endmodule
